// File: sv/kct_pkg.sv
// Package for the keyed transmitter configuration tracker.
// Holds shared constants, the controller state type, the command/status structs and a byte-swap function.
// No dependencies.
`default_nettype none
package kct_pkg;

    localparam int K_ENTRIES          = 3;
    localparam int K_CODE_COUNT       = 256;
    localparam int K_FLOAT_CODE_LIMIT = 20;

    localparam logic [31:0] K_NAN_WORD     = 32'h7FC0_0000;
    localparam logic [31:0] K_TYPE_MODEL_A = 32'd228;
    localparam logic [31:0] K_TYPE_MODEL_B = 32'd229;
    localparam logic [31:0] K_TYPE_OZONE   = 32'd56;
    localparam logic [1:0]  K_CONFIRM_CNT  = 2'd2;
    localparam logic [1:0]  K_CNT_MAX      = 2'd3;

    localparam logic [1:0] K_PH_TYPE   = 2'd0;
    localparam logic [1:0] K_PH_NUMBER = 2'd1;
    localparam logic [1:0] K_PH_READY  = 2'd2;

    localparam logic K_CFG_TYPE_CODE = 1'b0;
    localparam logic K_CFG_NAME_CODE = 1'b1;

    localparam logic K_REQ_READ = 1'b1;

    typedef enum logic [3:0] {
        ST_CLR_ALL,
        ST_IDLE,
        ST_LOOK,
        ST_SCAN,
        ST_EVICT,
        ST_ALLOC,
        ST_CLR_ROW,
        ST_PROC,
        ST_RD_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic look;
        logic scan;
        logic evict;
        logic alloc;
        logic row_clr;
        logic clr_all;
        logic proc;
        logic rd;
    } t_cmd;

    typedef struct packed {
        logic is_read;
        logic found;
        logic full;
        logic scan_last;
        logic row_done;
        logic clr_done;
        logic out_free;
    } t_sts;

    function automatic logic [31:0] swap_bytes(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage
`default_nettype wire

// File: sv/keyed_sonde_config_tracker.sv
// Top level of the keyed transmitter configuration tracker.
// Depends on kct_pkg, kct_ctrl, kct_dp (which holds kct_ram).
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-------------------------------------
//  request  | in        | i_valid / o_stall    | req_type, key, code, data, time, slot
//  result   | out       | o_valid / i_stall    | slot, flags, phase, type, serial, word
//  config   | in        | i_cfg_we             | i_cfg_idx, i_cfg_data
//
// Known key or read request: accept, lookup, result load.
// New key with a free slot: lookup, allocation, sweep of its word-store row, result load.
// New key with a full table: a scan of all ENTRIES for a victim and an eviction come first.
// After reset a sweep of the whole word store (1024 words at defaults) holds o_stall high.
// A pending result under i_stall holds the next transaction at its result load.
`default_nettype none
module keyed_sonde_config_tracker #(
    parameter int ENTRIES          = kct_pkg::K_ENTRIES,
    parameter int CODE_COUNT       = kct_pkg::K_CODE_COUNT,
    parameter int FLOAT_CODE_LIMIT = kct_pkg::K_FLOAT_CODE_LIMIT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_req_type,
    input  wire logic [31:0] i_frequency_key,
    input  wire logic [7:0]  i_frame_code,
    input  wire logic [31:0] i_data_word,
    input  wire logic [31:0] i_timestamp,
    input  wire logic [2:0]  i_read_slot,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_slot,
    output logic             o_new_entry,
    output logic             o_evicted,
    output logic [1:0]       o_detector_phase,
    output logic [31:0]      o_sonde_type,
    output logic [31:0]      o_serial_number,
    output logic             o_model_flag,
    output logic             o_ozone_flag,
    output logic             o_name_known,
    output logic [31:0]      o_read_word
);
    import kct_pkg::*;

    t_cmd cmd;
    t_sts sts;

    kct_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    kct_dp #(
        .ENTRIES          (ENTRIES),
        .CODE_COUNT       (CODE_COUNT),
        .FLOAT_CODE_LIMIT (FLOAT_CODE_LIMIT)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_req_type       (i_req_type),
        .i_frequency_key  (i_frequency_key),
        .i_frame_code     (i_frame_code),
        .i_data_word      (i_data_word),
        .i_timestamp      (i_timestamp),
        .i_read_slot      (i_read_slot),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_slot           (o_slot),
        .o_new_entry      (o_new_entry),
        .o_evicted        (o_evicted),
        .o_detector_phase (o_detector_phase),
        .o_sonde_type     (o_sonde_type),
        .o_serial_number  (o_serial_number),
        .o_model_flag     (o_model_flag),
        .o_ozone_flag     (o_ozone_flag),
        .o_name_known     (o_name_known),
        .o_read_word      (o_read_word)
    );
endmodule
`default_nettype wire

// File: sv/kct_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module kct_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: sv/kct_ctrl.sv
// Controller state machine of the tracker.
// Depends on kct_pkg for the state type and the command/status structs.
`default_nettype none
module kct_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire kct_pkg::t_sts i_sts,
    output kct_pkg::t_cmd      o_cmd
);
    import kct_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR_ALL;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLR_ALL: if (i_sts.clr_done) n_state = ST_IDLE;
            ST_IDLE:    if (i_valid) n_state = ST_LOOK;
            ST_LOOK: begin
                if (i_sts.is_read) n_state = ST_RD_OUT;
                else if (i_sts.found) n_state = ST_PROC;
                else if (!i_sts.full) n_state = ST_ALLOC;
                else n_state = ST_SCAN;
            end
            ST_SCAN:    if (i_sts.scan_last) n_state = ST_EVICT;
            ST_EVICT:   n_state = ST_ALLOC;
            ST_ALLOC:   n_state = ST_CLR_ROW;
            ST_CLR_ROW: if (i_sts.row_done) n_state = ST_PROC;
            ST_PROC:    if (i_sts.out_free) n_state = ST_IDLE;
            ST_RD_OUT:  if (i_sts.out_free) n_state = ST_IDLE;
            default:    n_state = ST_CLR_ALL;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = (r_state != ST_IDLE);
        case (r_state)
            ST_CLR_ALL: o_cmd.clr_all = 1'b1;
            ST_IDLE:    o_cmd.load    = i_valid;
            ST_LOOK:    o_cmd.look    = 1'b1;
            ST_SCAN:    o_cmd.scan    = 1'b1;
            ST_EVICT:   o_cmd.evict   = 1'b1;
            ST_ALLOC:   o_cmd.alloc   = 1'b1;
            ST_CLR_ROW: o_cmd.row_clr = 1'b1;
            ST_PROC:    o_cmd.proc    = i_sts.out_free;
            ST_RD_OUT:  o_cmd.rd      = i_sts.out_free;
            default:    o_cmd         = '0;
        endcase
    end

    a_proc_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.proc |=> r_state == ST_IDLE)
        else $error("result load did not return to idle");
    a_clr_first: assert property (@(posedge i_clk)
        !i_rst_n |=> o_stall)
        else $error("accepting during clearing pass");
    a_scan_to_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.evict |-> $past(o_cmd.scan))
        else $error("eviction without victim scan");
endmodule
`default_nettype wire

// File: sv/kct_dp.sv
// Datapath of the tracker: entry table, detectors, word store and result register.
// Depends on kct_pkg and kct_ram.
`default_nettype none
module kct_dp #(
    parameter int ENTRIES          = kct_pkg::K_ENTRIES,
    parameter int CODE_COUNT       = kct_pkg::K_CODE_COUNT,
    parameter int FLOAT_CODE_LIMIT = kct_pkg::K_FLOAT_CODE_LIMIT
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire kct_pkg::t_cmd i_cmd,
    output kct_pkg::t_sts      o_sts,
    input  wire logic          i_cfg_we,
    input  wire logic          i_cfg_idx,
    input  wire logic [7:0]    i_cfg_data,
    input  wire logic          i_req_type,
    input  wire logic [31:0]   i_frequency_key,
    input  wire logic [7:0]    i_frame_code,
    input  wire logic [31:0]   i_data_word,
    input  wire logic [31:0]   i_timestamp,
    input  wire logic [2:0]    i_read_slot,
    input  wire logic          i_stall,
    output logic               o_valid,
    output logic [2:0]         o_slot,
    output logic               o_new_entry,
    output logic               o_evicted,
    output logic [1:0]         o_detector_phase,
    output logic [31:0]        o_sonde_type,
    output logic [31:0]        o_serial_number,
    output logic               o_model_flag,
    output logic               o_ozone_flag,
    output logic               o_name_known,
    output logic [31:0]        o_read_word
);
    import kct_pkg::*;

    localparam int SW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CB = $clog2(CODE_COUNT);
    localparam int AW = SW + CB;
    localparam logic [SW-1:0] LAST = SW'(ENTRIES - 1);
    localparam logic [8:0] CODE_LIM  = 9'(CODE_COUNT);
    localparam logic [8:0] FLOAT_LIM = 9'(FLOAT_CODE_LIMIT);
    localparam logic [3:0] ENT_LIM   = 4'(ENTRIES);

    logic [7:0] r_tcode, r_ncode;

    logic        r_req;
    logic [31:0] r_key, r_data, r_now;
    logic [7:0]  r_code;
    logic [2:0]  r_rslot;

    logic          r_valid [ENTRIES];
    logic [31:0]   r_ekey  [ENTRIES];
    logic [31:0]   r_time  [ENTRIES];
    logic [SW-1:0] r_order [ENTRIES];
    logic [1:0]    r_phase [ENTRIES];
    logic [31:0]   r_cand  [ENTRIES];
    logic [1:0]    r_mcnt  [ENTRIES];
    logic [31:0]   r_ctype [ENTRIES];
    logic [31:0]   r_cnum  [ENTRIES];
    logic [1:0]    r_flags [ENTRIES];

    logic [SW-1:0] r_slot, r_victim, r_vorder;
    logic [31:0]   r_vtime;
    logic          r_have, r_new, r_evict;
    logic [AW-1:0] r_clr;
    logic          r_ovalid;

    logic          found, full;
    logic [SW-1:0] found_idx, free_idx;
    logic [SW:0]   cnt;
    logic          code_ok, rd_in_range, better;

    logic [1:0]  np, nmc;
    logic [31:0] ncand, nctype, ncnum;
    logic [1:0]  nflags;
    logic [1:0]  mc1;
    logic        store;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [32:0]   ram_wdata, ram_rdata;
    logic [31:0]   rd_word;

    always_comb begin
        found     = 1'b0;
        found_idx = '0;
        free_idx  = '0;
        full      = 1'b1;
        cnt       = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (r_valid[i] && r_ekey[i] == r_key) begin
                found     = 1'b1;
                found_idx = SW'(i);
            end
            if (!r_valid[i]) begin
                free_idx = SW'(i);
                full     = 1'b0;
            end
            cnt = cnt + (SW+1)'(r_valid[i]);
        end
    end

    assign code_ok     = {1'b0, r_code} < CODE_LIM;
    assign rd_in_range = {1'b0, r_rslot} < ENT_LIM;
    assign better      = !r_have || r_time[r_slot] < r_vtime ||
                         (r_time[r_slot] == r_vtime && r_order[r_slot] < r_vorder);

    always_comb begin
        np     = r_phase[r_slot];
        nmc    = r_mcnt[r_slot];
        ncand  = r_cand[r_slot];
        nctype = r_ctype[r_slot];
        ncnum  = r_cnum[r_slot];
        nflags = r_flags[r_slot];
        mc1    = (r_mcnt[r_slot] == K_CNT_MAX) ? K_CNT_MAX : r_mcnt[r_slot] + 2'd1;
        if (r_phase[r_slot] == K_PH_TYPE && r_code == r_tcode) begin
            if (r_data == r_cand[r_slot]) begin
                nmc = mc1;
                if (mc1 >= K_CONFIRM_CNT) begin
                    nctype = r_data;
                    np     = K_PH_NUMBER;
                    nmc    = 2'd0;
                    ncand  = '0;
                    nflags = {(r_data == K_TYPE_OZONE || r_data == K_TYPE_MODEL_B),
                              (r_data == K_TYPE_MODEL_A || r_data == K_TYPE_MODEL_B)};
                end
            end else begin
                ncand = r_data;
                nmc   = 2'd1;
            end
        end else if (r_phase[r_slot] == K_PH_NUMBER && r_code == r_ncode) begin
            if (r_data == r_cand[r_slot]) begin
                nmc = mc1;
                if (mc1 >= K_CONFIRM_CNT) begin
                    ncnum = r_data;
                    np    = K_PH_READY;
                end
            end else begin
                ncand = r_data;
                nmc   = 2'd1;
            end
        end
        store = (np != K_PH_TYPE) && r_code != r_tcode && r_code != r_ncode && code_ok;
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_clr;
        ram_wdata = '0;
        if (i_cmd.clr_all) begin
            ram_we = 1'b1;
        end else if (i_cmd.row_clr) begin
            ram_we    = 1'b1;
            ram_waddr = {r_slot, r_clr[CB-1:0]};
        end else if (i_cmd.proc && store) begin
            ram_we    = 1'b1;
            ram_waddr = {r_slot, r_code[CB-1:0]};
            ram_wdata = {1'b1, r_data};
        end
    end

    assign ram_raddr = {r_rslot[SW-1:0], r_code[CB-1:0]};

    kct_ram #(.WIDTH(33), .DEPTH(1 << AW)) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        rd_word = '0;
        if (code_ok) begin
            if (ram_rdata[32]) rd_word = ram_rdata[31:0];
            else if ({1'b0, r_code} < FLOAT_LIM) rd_word = K_NAN_WORD;
        end
    end

    always_comb begin
        o_sts.is_read   = (r_req == K_REQ_READ);
        o_sts.found     = found;
        o_sts.full      = full;
        o_sts.scan_last = (r_slot == LAST);
        o_sts.row_done  = &r_clr[CB-1:0];
        o_sts.clr_done  = &r_clr;
        o_sts.out_free  = !r_ovalid || !i_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tcode <= 8'd0;
            r_ncode <= 8'd1;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == K_CFG_TYPE_CODE) r_tcode <= i_cfg_data;
            if (i_cfg_idx == K_CFG_NAME_CODE) r_ncode <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_all || i_cmd.row_clr) begin
            r_clr <= r_clr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req   <= i_req_type;
            r_key   <= i_frequency_key;
            r_code  <= i_frame_code;
            r_data  <= swap_bytes(i_data_word);
            r_now   <= i_timestamp;
            r_rslot <= i_read_slot;
        end
        if (i_cmd.look) begin
            r_have  <= 1'b0;
            r_new   <= (r_req != K_REQ_READ) && !found;
            r_evict <= (r_req != K_REQ_READ) && !found && full;
            if (r_req == K_REQ_READ) r_slot <= r_rslot[SW-1:0];
            else if (found) r_slot <= found_idx;
            else if (full) r_slot <= '0;
            else r_slot <= free_idx;
        end
        if (i_cmd.scan) begin
            if (better) begin
                r_victim <= r_slot;
                r_vtime  <= r_time[r_slot];
                r_vorder <= r_order[r_slot];
                r_have   <= 1'b1;
            end
            if (r_slot != LAST) r_slot <= r_slot + SW'(1);
        end
        if (i_cmd.evict) begin
            r_slot <= r_victim;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                r_valid[i] <= 1'b0;
                r_ekey[i]  <= '0;
                r_time[i]  <= '0;
                r_order[i] <= '0;
                r_phase[i] <= K_PH_TYPE;
                r_cand[i]  <= '0;
                r_mcnt[i]  <= '0;
                r_ctype[i] <= '0;
                r_cnum[i]  <= '0;
                r_flags[i] <= '0;
            end
        end else begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (i_cmd.evict) begin
                    if (r_order[i] > r_vorder) r_order[i] <= r_order[i] - SW'(1);
                    if (SW'(i) == r_victim) r_valid[i] <= 1'b0;
                end
                if (i_cmd.alloc && SW'(i) == r_slot) begin
                    r_valid[i] <= 1'b1;
                    r_ekey[i]  <= r_key;
                    r_order[i] <= cnt[SW-1:0];
                    r_phase[i] <= K_PH_TYPE;
                    r_cand[i]  <= '0;
                    r_mcnt[i]  <= '0;
                    r_ctype[i] <= '0;
                    r_cnum[i]  <= '0;
                    r_flags[i] <= '0;
                end
                if (i_cmd.proc && SW'(i) == r_slot) begin
                    r_time[i]  <= r_now;
                    r_phase[i] <= np;
                    r_cand[i]  <= ncand;
                    r_mcnt[i]  <= nmc;
                    r_ctype[i] <= nctype;
                    r_cnum[i]  <= ncnum;
                    r_flags[i] <= nflags;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.proc || i_cmd.rd) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.proc) begin
            o_slot           <= 3'(r_slot);
            o_new_entry      <= r_new;
            o_evicted        <= r_evict;
            o_detector_phase <= np;
            o_sonde_type     <= nctype;
            o_serial_number  <= ncnum;
            o_model_flag     <= nflags[0];
            o_ozone_flag     <= nflags[1];
            o_name_known     <= (np == K_PH_READY);
            o_read_word      <= '0;
        end else if (i_cmd.rd) begin
            o_slot      <= r_rslot;
            o_new_entry <= 1'b0;
            o_evicted   <= 1'b0;
            if (rd_in_range && r_valid[r_slot]) begin
                o_detector_phase <= r_phase[r_slot];
                o_sonde_type     <= r_ctype[r_slot];
                o_serial_number  <= r_cnum[r_slot];
                o_model_flag     <= r_flags[r_slot][0];
                o_ozone_flag     <= r_flags[r_slot][1];
                o_name_known     <= (r_phase[r_slot] == K_PH_READY);
                o_read_word      <= rd_word;
            end else begin
                o_detector_phase <= '0;
                o_sonde_type     <= '0;
                o_serial_number  <= '0;
                o_model_flag     <= 1'b0;
                o_ozone_flag     <= 1'b0;
                o_name_known     <= 1'b0;
                o_read_word      <= '0;
            end
        end
    end

    assign o_valid = r_ovalid;

    a_proc_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.proc |-> r_slot <= LAST && r_valid[r_slot])
        else $error("frame processed on a free slot");
    a_evict_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.evict |=> !full)
        else $error("eviction left the table full");
    a_load_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.proc || i_cmd.rd) |-> !r_ovalid || !i_stall)
        else $error("result overwrote a pending transaction");
endmodule
`default_nettype wire

// File: dv/tb_keyed_sonde_config_tracker.sv
// Testbench for keyed_sonde_config_tracker: queue-fed driver, clocked monitor and a
// transaction-level predictor of the transmitter table, detectors and word store.
// Depends on kct_pkg and the RTL of the tracker.
`timescale 1ns / 1ps
module tb_keyed_sonde_config_tracker;
    import kct_pkg::*;

    localparam int NENT      = K_ENTRIES;
    localparam int NCODE     = K_CODE_COUNT;
    localparam int IDLE_LIMIT = 4000;

    typedef struct packed {
        logic        req_type;
        logic [31:0] key;
        logic [7:0]  code;
        logic [31:0] data;
        logic [31:0] stamp;
        logic [2:0]  rslot;
    } frame_t;

    typedef struct packed {
        logic [2:0]  slot;
        logic        new_entry;
        logic        evicted;
        logic [1:0]  phase;
        logic [31:0] stype;
        logic [31:0] serial;
        logic        model;
        logic        ozone;
        logic        known;
        logic [31:0] word;
    } status_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = K_CFG_TYPE_CODE;
    logic [7:0]  i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_req_type = 1'b0;
    logic [31:0] i_frequency_key = '0;
    logic [7:0]  i_frame_code = '0;
    logic [31:0] i_data_word = '0;
    logic [31:0] i_timestamp = '0;
    logic [2:0]  i_read_slot = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_slot;
    logic        o_new_entry, o_evicted, o_model_flag, o_ozone_flag, o_name_known;
    logic [1:0]  o_detector_phase;
    logic [31:0] o_sonde_type, o_serial_number, o_read_word;

    keyed_sonde_config_tracker u_top (.*);

    // predictor state
    logic [7:0]  code_type, code_name;
    logic        tv[NENT];
    logic [31:0] tkey[NENT], ttime[NENT], cand[NENT], ctype[NENT], cnum[NENT];
    logic [1:0]  tord[NENT], tph[NENT], mcnt[NENT], tflg[NENT];
    logic [31:0] wstore[NENT][NCODE];
    logic        wset[NENT][NCODE];

    frame_t  pend_frames[$];
    status_t expected_status[$];
    int      errors = 0;
    int      idle_cycles = 0;
    int      gap_left = 0, stall_left = 0;
    bit      calm = 0;
    bit      req_fire = 0;
    bit      running = 0;

    function automatic logic [31:0] byte_rev(input logic [31:0] v);
        return {<<8{v}};
    endfunction

    function automatic int draw_wait();
        return calm ? 0 : $urandom_range(0, 14);
    endfunction

    function automatic void entry_view(input int s, inout status_t r);
        r.phase  = tph[s];
        r.stype  = ctype[s];
        r.serial = cnum[s];
        r.model  = tflg[s][0];
        r.ozone  = tflg[s][1];
        r.known  = (tph[s] == K_PH_READY);
    endfunction

    function automatic status_t track_frame(input frame_t f);
        status_t     r;
        logic [31:0] d;
        int          s, cnt, victim;
        bit          found, have;
        r = '0;
        d = byte_rev(f.data);
        s = 0;
        cnt = 0;
        found = 0;
        if (f.req_type == K_REQ_READ) begin
            r.slot = f.rslot;
            if (f.rslot < NENT && tv[f.rslot]) begin
                entry_view(f.rslot, r);
                if (wset[f.rslot][f.code]) r.word = wstore[f.rslot][f.code];
                else r.word = (f.code < K_FLOAT_CODE_LIMIT) ? K_NAN_WORD : 32'd0;
            end
            return r;
        end
        for (int i = 0; i < NENT; i++) begin
            if (tv[i]) begin
                cnt++;
                if (!found && tkey[i] == f.key) begin
                    found = 1;
                    s = i;
                end
            end
        end
        if (!found) begin
            if (cnt >= NENT) begin
                victim = 0;
                have = 0;
                for (int i = 0; i < NENT; i++)
                    if (!have || ttime[i] < ttime[victim] ||
                        (ttime[i] == ttime[victim] && tord[i] < tord[victim])) begin
                        victim = i;
                        have = 1;
                    end
                for (int i = 0; i < NENT; i++)
                    if (tord[i] > tord[victim]) tord[i]--;
                tv[victim] = 0;
                cnt--;
                r.evicted = 1;
            end
            for (int i = NENT - 1; i >= 0; i--)
                if (!tv[i]) s = i;
            tv[s] = 1;
            tkey[s] = f.key;
            ttime[s] = 0;
            tord[s] = 2'(cnt);
            tph[s] = K_PH_TYPE;
            cand[s] = 0;
            mcnt[s] = 0;
            ctype[s] = 0;
            cnum[s] = 0;
            tflg[s] = 0;
            for (int c = 0; c < NCODE; c++) wset[s][c] = 0;
            r.new_entry = 1;
        end
        if (tph[s] == K_PH_TYPE && f.code == code_type) begin
            if (d == cand[s]) begin
                if (mcnt[s] < K_CNT_MAX) mcnt[s]++;
                if (mcnt[s] >= K_CONFIRM_CNT) begin
                    ctype[s] = d;
                    tph[s] = K_PH_NUMBER;
                    mcnt[s] = 0;
                    cand[s] = 0;
                    tflg[s][0] = (d == K_TYPE_MODEL_A || d == K_TYPE_MODEL_B);
                    tflg[s][1] = (d == K_TYPE_OZONE || d == K_TYPE_MODEL_B);
                end
            end else begin
                cand[s] = d;
                mcnt[s] = 1;
            end
        end else if (tph[s] == K_PH_NUMBER && f.code == code_name) begin
            if (d == cand[s]) begin
                if (mcnt[s] < K_CNT_MAX) mcnt[s]++;
                if (mcnt[s] >= K_CONFIRM_CNT) begin
                    cnum[s] = d;
                    tph[s] = K_PH_READY;
                end
            end else begin
                cand[s] = d;
                mcnt[s] = 1;
            end
        end
        if (tph[s] != K_PH_TYPE && f.code != code_type && f.code != code_name) begin
            wstore[s][f.code] = d;
            wset[s][f.code] = 1;
        end
        ttime[s] = f.stamp;
        r.slot = 3'(s);
        entry_view(s, r);
        return r;
    endfunction

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // request and result side: sample handshakes, predict, compare results, watchdog
    always @(posedge i_clk) begin
        req_fire = i_valid && !o_stall;
        if (req_fire)
            expected_status.push_back(track_frame({i_req_type, i_frequency_key, i_frame_code,
                                                   i_data_word, i_timestamp, i_read_slot}));
        if (o_valid && !i_stall) begin
            stall_left = draw_wait();
            if (expected_status.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", o_slot);
            end else begin
                status_t want, got;
                want = expected_status.pop_front();
                got = {o_slot, o_new_entry, o_evicted, o_detector_phase, o_sonde_type,
                       o_serial_number, o_model_flag, o_ozone_flag, o_name_known, o_read_word};
                if (got !== want) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch exp slot=%0d new=%b ev=%b ph=%0d ty=%h sn=%h m=%b o=%b k=%b w=%h | act slot=%0d new=%b ev=%b ph=%0d ty=%h sn=%h m=%b o=%b k=%b w=%h",
                            want.slot, want.new_entry, want.evicted, want.phase, want.stype,
                            want.serial, want.model, want.ozone, want.known, want.word,
                            got.slot, got.new_entry, got.evicted, got.phase, got.stype,
                            got.serial, got.model, got.ozone, got.known, got.word);
                end
            end
        end
        if (running) begin
            if (req_fire || (o_valid && !i_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    always @(negedge i_clk) begin
        if (running) begin
            if (i_valid && !req_fire) begin
            end else if (gap_left > 0) begin
                i_valid <= 1'b0;
                gap_left--;
            end else if (pend_frames.size() > 0) begin
                frame_t f;
                f = pend_frames.pop_front();
                i_req_type <= f.req_type;
                i_frequency_key <= f.key;
                i_frame_code <= f.code;
                i_data_word <= f.data;
                i_timestamp <= f.stamp;
                i_read_slot <= f.rslot;
                i_valid <= 1'b1;
                gap_left = draw_wait();
                if ($urandom_range(0, 99) == 0) calm = !calm;
            end else begin
                i_valid <= 1'b0;
            end
            if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    task automatic add_frame(input logic rq, input logic [31:0] k, input logic [7:0] c,
                             input logic [31:0] d, input logic [31:0] t, input logic [2:0] rs);
        frame_t f;
        f = {rq, k, c, d, t, rs};
        pend_frames.push_back(f);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        if (idx == K_CFG_TYPE_CODE) code_type = val;
        else code_name = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic settle();
        wait (pend_frames.size() == 0 && expected_status.size() == 0 && !i_valid);
        repeat (20) @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_stamp();
        return ($urandom_range(0, 1) == 0) ? $urandom_range(0, 7) : $urandom;
    endfunction

    task automatic random_phase(input int n);
        logic [31:0] keys[5];
        logic [31:0] k, w;
        logic [7:0]  nc;
        keys[0] = 32'd0;
        keys[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 5; i++) keys[i] = $urandom;
        while (n > 0) begin
            k = keys[$urandom_range(0, 4)];
            case ($urandom_range(0, 4))
                0: w = K_TYPE_MODEL_A;
                1: w = K_TYPE_MODEL_B;
                2: w = K_TYPE_OZONE;
                default: w = $urandom;
            endcase
            if ($urandom_range(0, 3) == 0)
                add_frame(1'b0, k, code_type, byte_rev($urandom), rand_stamp(), 3'd0);
            if ($urandom_range(0, 5) != 0)
                add_frame(1'b0, k, code_type, byte_rev(w), rand_stamp(), 3'd0);
            add_frame(1'b0, k, code_type, byte_rev(w), rand_stamp(), 3'd0);
            w = $urandom;
            if ($urandom_range(0, 5) != 0)
                add_frame(1'b0, k, code_name, byte_rev(w), rand_stamp(), 3'd0);
            add_frame(1'b0, k, code_name, byte_rev(w), rand_stamp(), 3'd0);
            for (int j = $urandom_range(1, 5); j > 0; j--) begin
                nc = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 24) : $urandom;
                add_frame(1'b0, k, nc, $urandom, rand_stamp(), 3'd0);
            end
            for (int j = $urandom_range(1, 4); j > 0; j--) begin
                nc = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 24) : $urandom;
                add_frame(1'b1, $urandom, nc, $urandom, $urandom, $urandom_range(0, 7));
            end
            if ($urandom_range(0, 3) == 0)
                add_frame($urandom, keys[$urandom_range(0, 4)], $urandom, $urandom,
                          rand_stamp(), $urandom);
            n -= 10;
        end
    endtask

    initial begin
        code_type = 8'd0;
        code_name = 8'd1;
        for (int i = 0; i < NENT; i++) begin
            tv[i] = 0; tkey[i] = 0; ttime[i] = 0; tord[i] = 0; tph[i] = K_PH_TYPE;
            cand[i] = 0; mcnt[i] = 0; ctype[i] = 0; cnum[i] = 0; tflg[i] = 0;
            for (int c = 0; c < NCODE; c++) begin
                wstore[i][c] = 0;
                wset[i][c] = 0;
            end
        end
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        running = 1;

        // reset values of the code registers first
        add_frame(1'b1, 32'd0, 8'd0, 32'd0, 32'd0, 3'd0);
        add_frame(1'b1, 32'd0, 8'hFF, 32'd0, 32'd0, 3'd7);
        add_frame(1'b0, 32'd0, 8'd0, byte_rev(K_TYPE_MODEL_B), 32'd5, 3'd0);
        add_frame(1'b0, 32'd0, 8'd0, byte_rev(K_TYPE_MODEL_B), 32'd6, 3'd0);
        add_frame(1'b0, 32'd0, 8'd1, 32'hFFFF_FFFF, 32'd7, 3'd0);
        add_frame(1'b0, 32'd0, 8'd1, 32'hFFFF_FFFF, 32'd8, 3'd0);
        add_frame(1'b0, 32'd0, 8'd5, 32'h1234_5678, 32'hFFFF_FFFF, 3'd0);
        add_frame(1'b0, 32'd0, 8'hFF, 32'hA5A5_5A5A, 32'hFFFF_FFFF, 3'd0);
        add_frame(1'b1, 32'd0, 8'd5, 32'd0, 32'd0, 3'd0);
        add_frame(1'b1, 32'd0, 8'hFF, 32'd0, 32'd0, 3'd0);
        add_frame(1'b1, 32'd0, 8'd3, 32'd0, 32'd0, 3'd0);
        add_frame(1'b1, 32'd0, 8'd19, 32'd0, 32'd0, 3'd0);
        add_frame(1'b1, 32'd0, 8'd20, 32'd0, 32'd0, 3'd0);
        add_frame(1'b1, 32'd0, 8'd0, 32'd0, 32'd0, 3'd5);
        add_frame(1'b0, 32'hFFFF_FFFF, 8'd0, byte_rev(K_TYPE_OZONE), 32'd0, 3'd0);
        add_frame(1'b0, 32'hFFFF_FFFF, 8'd0, byte_rev(K_TYPE_OZONE), 32'd0, 3'd0);
        add_frame(1'b0, 32'd2, 8'd0, byte_rev(K_TYPE_MODEL_A), 32'd0, 3'd0);
        add_frame(1'b0, 32'd2, 8'd0, byte_rev(K_TYPE_MODEL_A), 32'd0, 3'd0);
        add_frame(1'b0, 32'd3, 8'd9, 32'h0BAD_F00D, 32'd1, 3'd0);
        add_frame(1'b0, 32'd4, 8'd9, 32'd0, 32'd1, 3'd0);
        add_frame(1'b1, 32'd0, 8'd9, 32'd0, 32'd0, 3'd1);
        add_frame(1'b1, 32'd0, 8'd9, 32'd0, 32'd0, 3'd2);
        random_phase(200);
        settle();

        write_reg(K_CFG_TYPE_CODE, 8'hFF);
        write_reg(K_CFG_NAME_CODE, 8'hFE);
        random_phase(200);
        settle();

        write_reg(K_CFG_TYPE_CODE, 8'd7);
        write_reg(K_CFG_NAME_CODE, 8'd7);
        random_phase(150);
        settle();

        write_reg(K_CFG_TYPE_CODE, 8'd0);
        write_reg(K_CFG_NAME_CODE, 8'hFF);
        random_phase(200);
        settle();

        write_reg(K_CFG_TYPE_CODE, $urandom);
        write_reg(K_CFG_NAME_CODE, $urandom);
        random_phase(250);

        wait (pend_frames.size() == 0 && expected_status.size() == 0 && !i_valid);
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
